/* hdl/led_ring_clock_frame_render_top_defines.svh */
// Assertion macros for the clock-ring frame renderer.
// Used by the top level only; expects clk and rst in scope.
`ifndef LED_RING_CLOCK_FRAME_RENDER_TOP_DEFINES_SVH
`define LED_RING_CLOCK_FRAME_RENDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LRCFR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LRCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRCFR_ASSERT_IMPLY(label, ante, cons, msg)
`define LRCFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/lrcfr_pkg.sv */
// Types, constants and the fade table shared by the clock-ring frame renderer.
// No dependencies.
package lrcfr_pkg;

  localparam int RING            = 60;
  localparam int ROTATE          = 30;
  localparam int MARK_STEP       = 5;
  localparam int LOG_TABLE_DEPTH = 255;
  localparam int NUM_TAPS        = 6;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W      = 8;

  localparam logic [5:0] LAST_PIXEL = 6'(RING - 1);
  localparam logic [9:0] MS_MAX     = 10'd999;

  localparam logic [5:0] TAIL_NEAR_LIN = 6'd25;
  localparam logic [5:0] TAIL_FAR_LIN  = 6'd35;
  localparam logic [5:0] TAIL_NEAR_LOG = 6'd28;
  localparam logic [5:0] TAIL_FAR_LOG  = 6'd32;

  typedef enum logic [2:0] {
    REG_COLOR_SCHEME,
    REG_SECONDS_SCHEME,
    REG_BACKLIGHT_RED,
    REG_BACKLIGHT_GREEN,
    REG_BACKLIGHT_BLUE,
    REG_MARK_RED,
    REG_MARK_GREEN,
    REG_MARK_BLUE
  } reg_index_t;

  localparam logic [1:0] COL_HOUR_MINUTE = 2'd0;
  localparam logic [1:0] COL_BAR         = 2'd1;

  localparam logic [2:0] SEC_LINEAR       = 3'd0;
  localparam logic [2:0] SEC_LOG          = 3'd1;
  localparam logic [2:0] SEC_LINEAR_TAILS = 3'd2;
  localparam logic [2:0] SEC_LOG_TAILS    = 3'd3;

  typedef struct packed {
    logic [15:0] half_day_second;
    logic [9:0]  millisecond;
  } sample_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [1:0] color_scheme;
    logic [2:0] seconds_scheme;
    logic [7:0] backlight_red;
    logic [7:0] backlight_green;
    logic [7:0] backlight_blue;
    logic [7:0] mark_red;
    logic [7:0] mark_green;
    logic [7:0] mark_blue;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    color_scheme:    2'd1,
    seconds_scheme:  3'd0,
    backlight_red:   8'd2,
    backlight_green: 8'd2,
    backlight_blue:  8'd2,
    mark_red:        8'd25,
    mark_green:      8'd25,
    mark_blue:       8'd25
  };

  // Everything the back end needs to paint one frame
  typedef struct packed {
    logic [5:0]                hr;
    logic [5:0]                hr1;
    logic [5:0]                hrm;
    logic [5:0]                mn;
    logic [5:0]                mn1;
    logic [6:0]                bar_lo;
    logic [6:0]                bar_hi;
    logic [6:0]                g_mn;
    logic [6:0]                g_mn1;
    logic [NUM_TAPS-1:0][5:0]  tap_pos;
    logic [NUM_TAPS-1:0][7:0]  tap_amt;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] LOG_ROM [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd2, 8'd2,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
    8'd8, 8'd8, 8'd8, 8'd8, 8'd8,
    8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
    8'd10, 8'd10, 8'd10, 8'd10,
    8'd11, 8'd11, 8'd11, 8'd11,
    8'd12, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14,
    8'd15, 8'd15, 8'd15, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17, 8'd17,
    8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20, 8'd20, 8'd21, 8'd21,
    8'd22, 8'd22, 8'd23, 8'd23,
    8'd24, 8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29, 8'd29,
    8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd34,
    8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
    8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49,
    8'd50, 8'd51, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd59, 8'd60, 8'd61,
    8'd63, 8'd64, 8'd66, 8'd67, 8'd69, 8'd70,
    8'd72, 8'd73, 8'd75, 8'd77, 8'd78, 8'd80, 8'd82, 8'd84, 8'd86, 8'd87,
    8'd89, 8'd91, 8'd93, 8'd96, 8'd98, 8'd100,
    8'd102, 8'd104, 8'd107, 8'd109, 8'd111, 8'd114, 8'd116, 8'd119,
    8'd122, 8'd124, 8'd127, 8'd130, 8'd133, 8'd136,
    8'd139, 8'd142, 8'd145, 8'd148, 8'd151, 8'd155, 8'd158, 8'd162,
    8'd165, 8'd169, 8'd173, 8'd177, 8'd180, 8'd184,
    8'd188, 8'd193, 8'd197, 8'd201, 8'd206, 8'd210, 8'd215, 8'd220,
    8'd225, 8'd229, 8'd235, 8'd240, 8'd245, 8'd250
  };

  // Indices at or past LOG_TABLE_DEPTH read entry LOG_TABLE_DEPTH - 1
  function automatic logic [7:0] log_level(input logic [7:0] idx);
    logic [7:0] a;
    a = (int'(idx) >= LOG_TABLE_DEPTH) ? 8'(LOG_TABLE_DEPTH - 1) : idx;
    return LOG_ROM[a];
  endfunction

endpackage

/* hdl/lrcfr_front.sv */
// Front end: takes a time sample, splits it into ring positions and fade levels
// in its divide, split and place states and pushes a frame descriptor. Depends on lrcfr_pkg.
module lrcfr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lrcfr_pkg::sample_t    sample,
  input  logic [2:0]            seconds_scheme,
  input  lrcfr_pkg::q_status_t  q_status,
  output logic                  busy,
  output logic                  push,
  output lrcfr_pkg::frame_t     frame
);
  import lrcfr_pkg::*;

  // Reciprocals, each exact over the range it is applied to
  localparam logic [32:0] RECIP_60_T  = 33'd69906;  // t / 60, shift 22
  localparam logic [19:0] RECIP_5_MS  = 20'd820;    // ms / 5 shift 12, ms / 10 shift 13
  localparam logic [19:0] RECIP_50_MS = 20'd656;    // ms / 50 shift 15, ms / 100 shift 16
  localparam logic [21:0] RECIP_60_Q  = 22'd1093;   // q / 60, shift 16
  localparam logic [23:0] RECIP_12_Q  = 24'd5462;   // q / 12, shift 16

  typedef enum logic [2:0] {F_IDLE, F_DIV, F_SPLIT, F_PLACE, F_PUSH} state_t;

  state_t      state;
  logic [15:0] t_r;
  logic [9:0]  ms_r;
  logic [10:0] q1;
  logic [7:0]  ms5;
  logic [6:0]  ms10;
  logic [4:0]  ms50;
  logic [3:0]  ms100;
  logic [5:0]  sec;
  logic [5:0]  q2;
  logic [6:0]  q3;
  logic [5:0]  mn;
  logic [5:0]  hr;
  logic [NUM_TAPS-1:0][5:0] tap_pos;
  logic [NUM_TAPS-1:0][7:0] tap_amt;

  logic [32:0] prod_t;
  logic [19:0] prod_ms5;
  logic [19:0] prod_ms50;
  logic [21:0] prod_q2;
  logic [23:0] prod_q3;
  logic [5:0]  sec_next;
  logic [5:0]  mn_next;
  logic [5:0]  hr_next;
  logic [5:0]  sec1;
  logic [7:0]  ms4;
  logic [NUM_TAPS-1:0][5:0] tap_pos_next;
  logic [NUM_TAPS-1:0][7:0] tap_amt_next;

  function automatic logic [5:0] ring_add(input logic [5:0] a, input logic [5:0] off);
    logic [6:0] sum;
    sum = 7'(a) + 7'(off);
    return (sum >= 7'(RING)) ? 6'(sum - 7'(RING)) : 6'(sum);
  endfunction

  assign prod_t    = 33'(t_r) * RECIP_60_T;
  assign prod_ms5  = 20'(ms_r) * RECIP_5_MS;
  assign prod_ms50 = 20'(ms_r) * RECIP_50_MS;
  assign prod_q2   = 22'(q1) * RECIP_60_Q;
  assign prod_q3   = 24'(q1) * RECIP_12_Q;
  assign sec_next  = 6'(t_r - 16'(q1) * 16'(RING));
  assign mn_next   = 6'(q1 - 11'(q2) * 11'(RING));
  assign hr_next   = (q3 >= 7'(RING)) ? 6'(q3 - 7'(RING)) : 6'(q3);
  assign sec1      = (sec == LAST_PIXEL) ? 6'd0 : sec + 6'd1;
  assign ms4       = ms_r[9:2];

  // Place the blue fade taps; unused taps carry nothing
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      tap_pos_next[i] = sec;
      tap_amt_next[i] = '0;
    end
    tap_pos_next[1] = sec1;
    case (seconds_scheme)
      SEC_LINEAR: begin
        tap_amt_next[0] = 8'd100 - 8'(ms10);
        tap_amt_next[1] = 8'(ms10);
      end
      SEC_LOG: begin
        tap_amt_next[0] = log_level(8'd250 - ms4);
        tap_amt_next[1] = log_level(ms4);
      end
      SEC_LINEAR_TAILS: begin
        tap_amt_next[0] = 8'd200 - ms5;
        tap_amt_next[1] = ms5;
        tap_pos_next[2] = ring_add(sec, TAIL_NEAR_LIN);
        tap_amt_next[2] = 8'd10 - 8'(ms100);
        tap_pos_next[3] = ring_add(sec1, TAIL_NEAR_LIN);
        tap_amt_next[3] = 8'(ms100);
        tap_pos_next[4] = ring_add(sec, TAIL_FAR_LIN);
        tap_amt_next[4] = 8'd20 - 8'(ms50);
        tap_pos_next[5] = ring_add(sec1, TAIL_FAR_LIN);
        tap_amt_next[5] = 8'(ms50);
      end
      SEC_LOG_TAILS: begin
        tap_amt_next[0] = log_level(8'd200 - ms5);
        tap_amt_next[1] = log_level(ms5);
        tap_pos_next[2] = ring_add(sec, TAIL_NEAR_LOG);
        tap_amt_next[2] = 8'd10 - 8'(ms100);
        tap_pos_next[3] = ring_add(sec1, TAIL_NEAR_LOG);
        tap_amt_next[3] = 8'(ms100);
        tap_pos_next[4] = ring_add(sec, TAIL_FAR_LOG);
        tap_amt_next[4] = 8'd20 - 8'(ms50);
        tap_pos_next[5] = ring_add(sec1, TAIL_FAR_LOG);
        tap_amt_next[5] = 8'(ms50);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            t_r   <= sample.half_day_second;
            ms_r  <= (sample.millisecond > MS_MAX) ? MS_MAX : sample.millisecond;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          q1    <= prod_t[32:22];
          ms5   <= prod_ms5[19:12];
          ms10  <= prod_ms5[19:13];
          ms50  <= prod_ms50[19:15];
          ms100 <= prod_ms50[19:16];
          state <= F_SPLIT;
        end
        F_SPLIT: begin
          sec   <= sec_next;
          q2    <= prod_q2[21:16];
          q3    <= prod_q3[22:16];
          state <= F_PLACE;
        end
        F_PLACE: begin
          mn      <= mn_next;
          hr      <= hr_next;
          tap_pos <= tap_pos_next;
          tap_amt <= tap_amt_next;
          state   <= F_PUSH;
        end
        F_PUSH: begin
          // hold the descriptor until the queue has room
          if (!q_status.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !q_status.full;

  always_comb begin
    frame.hr      = hr;
    frame.hr1     = (hr == LAST_PIXEL) ? 6'd0 : hr + 6'd1;
    frame.hrm     = (hr == 6'd0) ? LAST_PIXEL : hr - 6'd1;
    frame.mn      = mn;
    frame.mn1     = (mn == LAST_PIXEL) ? 6'd0 : mn + 6'd1;
    frame.bar_lo  = 7'd60 - {1'b0, mn[5:1], 1'b0};
    frame.bar_hi  = 7'd60 + {1'b0, mn[5:1], 1'b0};
    frame.g_mn    = 7'd120 - {sec, 1'b0};
    frame.g_mn1   = {sec, 1'b0};
    frame.tap_pos = tap_pos;
    frame.tap_amt = tap_amt;
  end

endmodule

/* hdl/lrcfr_queue.sv */
// Two-entry descriptor queue between front and back end.
// Depends on lrcfr_pkg.
module lrcfr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lrcfr_pkg::frame_t     wr_frame,
  input  logic                  pop,
  output lrcfr_pkg::frame_t     rd_frame,
  output lrcfr_pkg::q_status_t  status
);
  import lrcfr_pkg::*;

  frame_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_frame;
    end
  end

  assign rd_frame     = entries[rd_ptr];
  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

/* hdl/lrcfr_back.sv */
// Back end: paints one pixel a cycle from the head descriptor, rotated by half
// a ring, and drives the registered result. Depends on lrcfr_pkg.
module lrcfr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lrcfr_pkg::cfg_t       cfg,
  input  lrcfr_pkg::q_status_t  q_status,
  input  lrcfr_pkg::frame_t     rd_frame,
  output logic                  pop,
  output logic                  strobe,
  output lrcfr_pkg::pixel_t     pixel
);
  import lrcfr_pkg::*;

  logic       active;
  frame_t     frame;
  logic [5:0] p_cnt;
  logic [5:0] src;
  logic [2:0] phase;

  logic       mark;
  logic [7:0] blue_add;
  logic [9:0] r;
  logic [9:0] g;
  logic [9:0] b;

  function automatic logic [7:0] sat8(input logic [9:0] v);
    return (v > 10'd255) ? 8'hFF : v[7:0];
  endfunction

  assign pop = !q_status.empty && (!active || (p_cnt == LAST_PIXEL));

  always_comb begin
    mark = (phase == 3'd0);
    r = 10'(cfg.backlight_red)   + (mark ? 10'(cfg.mark_red)   : 10'd0);
    g = 10'(cfg.backlight_green) + (mark ? 10'(cfg.mark_green) : 10'd0);
    b = 10'(cfg.backlight_blue)  + (mark ? 10'(cfg.mark_blue)  : 10'd0);

    // live taps sit on distinct positions, so at most one matches
    blue_add = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (src == frame.tap_pos[i]) begin
        blue_add = blue_add | frame.tap_amt[i];
      end
    end
    b = b + 10'(blue_add);

    case (cfg.color_scheme)
      COL_HOUR_MINUTE: begin
        if (src == frame.hr) begin
          g = g + 10'd128;
        end
        if (src == frame.mn) begin
          r = r + 10'd128;
        end
      end
      COL_BAR: begin
        // the hour bar replaces red outright
        if (src == frame.hrm) begin
          r = 10'(frame.bar_lo);
        end else if (src == frame.hr) begin
          r = 10'd120;
        end else if (src == frame.hr1) begin
          r = 10'(frame.bar_hi);
        end
        if (src == frame.mn) begin
          g = g + 10'(frame.g_mn);
        end else if (src == frame.mn1) begin
          g = g + 10'(frame.g_mn1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        pixel.pixel_index <= p_cnt;
        pixel.red         <= sat8(r);
        pixel.green       <= sat8(g);
        pixel.blue        <= sat8(b);
        pixel.last_pixel  <= (p_cnt == LAST_PIXEL);
      end
      if (pop) begin
        active <= 1'b1;
        frame  <= rd_frame;
        p_cnt  <= '0;
        src    <= 6'(ROTATE);
        phase  <= 3'(ROTATE % MARK_STEP);
      end else if (active) begin
        if (p_cnt == LAST_PIXEL) begin
          active <= 1'b0;
        end else begin
          p_cnt <= p_cnt + 6'd1;
          src   <= (src == LAST_PIXEL) ? 6'd0 : src + 6'd1;
          phase <= (phase == 3'(MARK_STEP - 1)) ? 3'd0 : phase + 3'd1;
        end
      end
    end
  end

endmodule

/* hdl/led_ring_clock_frame_render_top.sv */
// Clock-ring frame renderer: one time sample in, sixty RGB pixels out, one per
// cycle. A sample is taken when start is high and busy is low. The front end
// splits the sample into ring positions and fade levels in its divide, split
// and place states, then hands a descriptor to a two-frame queue; the back end
// paints one pixel per cycle from the head descriptor. The output pixel counter
// sets the sustained sample rate, and the front end can take a new sample while
// the back end still paints the last frame. busy is high while the front end
// works on a sample and stays high while a finished descriptor waits for room
// in a full queue. Pixels come with strobe and must be taken in the cycle they
// are shown.
// Depends on lrcfr_pkg, lrcfr_front, lrcfr_queue, lrcfr_back and the defines.
`include "led_ring_clock_frame_render_top_defines.svh"

module led_ring_clock_frame_render_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lrcfr_pkg::sample_t  sample,
  output logic                busy,
  output logic                strobe,
  output lrcfr_pkg::pixel_t   pixel,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [lrcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrcfr_pkg::*;

  cfg_t      cfg;
  logic      push;
  logic      pop;
  frame_t    wr_frame;
  frame_t    rd_frame;
  q_status_t q_status;

  logic       px_last;
  logic       mid_frame;
  logic [5:0] px_index;
  logic [5:0] px_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_COLOR_SCHEME:    cfg.color_scheme    <= cfg_data[1:0];
        REG_SECONDS_SCHEME:  cfg.seconds_scheme  <= cfg_data[2:0];
        REG_BACKLIGHT_RED:   cfg.backlight_red   <= cfg_data;
        REG_BACKLIGHT_GREEN: cfg.backlight_green <= cfg_data;
        REG_BACKLIGHT_BLUE:  cfg.backlight_blue  <= cfg_data;
        REG_MARK_RED:        cfg.mark_red        <= cfg_data;
        REG_MARK_GREEN:      cfg.mark_green      <= cfg_data;
        REG_MARK_BLUE:       cfg.mark_blue       <= cfg_data;
        default: ;
      endcase
    end
  end

  lrcfr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .sample         (sample),
    .seconds_scheme (cfg.seconds_scheme),
    .q_status       (q_status),
    .busy           (busy),
    .push           (push),
    .frame          (wr_frame)
  );

  lrcfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_frame (wr_frame),
    .pop      (pop),
    .rd_frame (rd_frame),
    .status   (q_status)
  );

  lrcfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .rd_frame (rd_frame),
    .pop      (pop),
    .strobe   (strobe),
    .pixel    (pixel)
  );

  assign px_last   = strobe && pixel.last_pixel;
  assign mid_frame = strobe && !pixel.last_pixel;
  assign px_index  = pixel.pixel_index;
  assign px_next   = pixel.pixel_index + 6'd1;

  `LRCFR_ASSERT_IMPLY(a_last_at_end, px_last, px_index == LAST_PIXEL, "last flag misplaced")
  `LRCFR_ASSERT_NEXT(a_frame_unbroken, mid_frame, strobe && px_index == $past(px_next), "frame torn")
  `LRCFR_ASSERT_IMPLY(a_frame_opens_at_zero, $rose(strobe), px_index == 6'd0, "opens off zero")
  `LRCFR_ASSERT_IMPLY(a_no_push_when_full, push, !q_status.full, "push into a full queue")

endmodule
